FILE: design/lrst_pkg.sv
package lrst_pkg;

  // Widths of the transaction fields
  localparam int unsigned CommandBits = 3;
  localparam int unsigned LeftBits    = 10;
  localparam int unsigned RightBits   = 11;
  localparam int unsigned OperandBits = 32;
  localparam int unsigned ResultBits  = 32;
  localparam int unsigned LengthBits  = 11;

  // Reset value of the used length register
  localparam logic [LengthBits-1:0] UsedLengthReset = 11'd1024;

  // Command codes
  typedef enum logic [CommandBits-1:0] {
    CMD_SET   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_RSUM  = 3'd2,
    CMD_PADD  = 3'd3,
    CMD_RADD  = 3'd4,
    CMD_TOTAL = 3'd5
  } cmd_e;

  // Datapath operations, one issued per cycle by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_STEP_DOWN,
    OP_PUSH_TAG,
    OP_PUSH_ZERO,
    OP_PUSH_C0,
    OP_PUSH_C1,
    OP_LEAF_RD,
    OP_LEAF_AP,
    OP_STEP_UP,
    OP_PULL_RD0,
    OP_PULL_RD1,
    OP_PULL_WR,
    OP_INIT_UP,
    OP_WALK_RD_A,
    OP_WALK_AP_A,
    OP_WALK_RD_B,
    OP_WALK_AP_B,
    OP_WALK_SHIFT,
    OP_ROOT_RD,
    OP_ROOT_AP,
    OP_OUT_LOAD
  } dp_op_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic go_done;
    logic is_total;
    logic is_point;
    logic is_get;
    logic is_radd;
    logic side_en;
    logic push_last;
    logic pull_last;
    logic a_lt_b;
    logic a_odd;
    logic b_odd;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/lazy_range_add_sum_tree.sv
// Handles one transaction at a time: a new command is taken only once the result of the
// last one has been loaded into the output register; the walk over the tree levels goes
// through the node and tag memories, each with one write and one registered read port.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the memories before
// the first transaction is taken.
module lazy_range_add_sum_tree #(
  parameter int unsigned TREE_LEVELS = 10,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [10:0] cfg_wdata_i,     // used_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // command, index_left, index_right, operand_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // result_value
  output logic        m_axis_tuser     // error
);
  import lrst_pkg::*;

  logic [CommandBits-1:0]        command;
  logic [LeftBits-1:0]           index_left;
  logic [RightBits-1:0]          index_right;
  logic signed [OperandBits-1:0] operand_value;
  logic signed [ResultBits-1:0]  result_value;
  logic                          error;
  dp_status_t                    status;
  dp_op_e                        op;

  // Unpack the input transaction
  assign command       = s_axis_tdata[2:0];
  assign index_left    = s_axis_tdata[12:3];
  assign index_right   = s_axis_tdata[23:13];
  assign operand_value = s_axis_tdata[55:24];

  lrst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .op_o       (op)
  );

  lrst_dpath #(
    .TREE_LEVELS (TREE_LEVELS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wen_i       (cfg_wen_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op),
    .command_i       (command),
    .index_left_i    (index_left),
    .index_right_i   (index_right),
    .operand_value_i (operand_value),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .result_value_o  (result_value),
    .error_o         (error)
  );

  // Pack the result transaction
  assign m_axis_tdata = result_value;
  assign m_axis_tuser = error;

endmodule

FILE: design/lrst_ctrl.sv
module lrst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lrst_pkg::dp_status_t  status_i,
  output lrst_pkg::dp_op_e      op_o
);
  import lrst_pkg::*;

  typedef enum logic [21:0] {
    S_CLR  = 22'h000001,
    S_IDLE = 22'h000002,
    S_DISP = 22'h000004,
    S_PSEL = 22'h000008,
    S_P0   = 22'h000010,
    S_P1   = 22'h000020,
    S_P2   = 22'h000040,
    S_P3   = 22'h000080,
    S_LRD  = 22'h000100,
    S_LAP  = 22'h000200,
    S_USEL = 22'h000400,
    S_U0   = 22'h000800,
    S_U1   = 22'h001000,
    S_U2   = 22'h002000,
    S_WA   = 22'h004000,
    S_WA2  = 22'h008000,
    S_WB   = 22'h010000,
    S_WB2  = 22'h020000,
    S_WSH  = 22'h040000,
    S_RRD  = 22'h080000,
    S_RAP  = 22'h100000,
    S_DONE = 22'h200000
  } state_e;

  state_e state_q, state_d;
  state_e after_push;

  // State register; the clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Point commands go to the leaf once the pushes are done, ranges to the walk
  assign after_push = status_i.is_point ? S_LRD : S_WA;

  // Next state and the operation for this cycle
  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        priority if (status_i.go_done) state_d = S_DONE;
        else if (status_i.is_total) state_d = S_RRD;
        else state_d = S_PSEL;
      end
      S_PSEL: begin
        if (status_i.side_en) begin
          state_d = S_P0;
        end else begin
          op_o    = OP_STEP_DOWN;
          state_d = status_i.push_last ? after_push : S_PSEL;
        end
      end
      S_P0: begin
        op_o    = OP_PUSH_TAG;
        state_d = S_P1;
      end
      S_P1: begin
        op_o    = OP_PUSH_ZERO;
        state_d = S_P2;
      end
      S_P2: begin
        op_o    = OP_PUSH_C0;
        state_d = S_P3;
      end
      S_P3: begin
        op_o    = OP_PUSH_C1;
        state_d = status_i.push_last ? after_push : S_PSEL;
      end
      S_LRD: begin
        op_o    = OP_LEAF_RD;
        state_d = S_LAP;
      end
      S_LAP: begin
        op_o    = OP_LEAF_AP;
        state_d = status_i.is_get ? S_DONE : S_USEL;
      end
      S_USEL: begin
        if (status_i.side_en) begin
          state_d = S_U0;
        end else begin
          op_o    = OP_STEP_UP;
          state_d = status_i.pull_last ? S_DONE : S_USEL;
        end
      end
      S_U0: begin
        op_o    = OP_PULL_RD0;
        state_d = S_U1;
      end
      S_U1: begin
        op_o    = OP_PULL_RD1;
        state_d = S_U2;
      end
      S_U2: begin
        op_o    = OP_PULL_WR;
        state_d = status_i.pull_last ? S_DONE : S_USEL;
      end
      S_WA: begin
        priority if (!status_i.a_lt_b) begin
          if (status_i.is_radd) begin
            op_o    = OP_INIT_UP;
            state_d = S_USEL;
          end else begin
            state_d = S_DONE;
          end
        end else if (status_i.a_odd) begin
          op_o    = OP_WALK_RD_A;
          state_d = S_WA2;
        end else begin
          state_d = S_WB;
        end
      end
      S_WA2: begin
        op_o    = OP_WALK_AP_A;
        state_d = S_WB;
      end
      S_WB: begin
        if (status_i.b_odd) begin
          op_o    = OP_WALK_RD_B;
          state_d = S_WB2;
        end else begin
          state_d = S_WSH;
        end
      end
      S_WB2: begin
        op_o    = OP_WALK_AP_B;
        state_d = S_WSH;
      end
      S_WSH: begin
        op_o    = OP_WALK_SHIFT;
        state_d = S_WA;
      end
      S_RRD: begin
        op_o    = OP_ROOT_RD;
        state_d = S_RAP;
      end
      S_RAP: begin
        op_o    = OP_ROOT_AP;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          op_o    = OP_OUT_LOAD;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lrst_dpath.sv
module lrst_dpath #(
  parameter int unsigned TREE_LEVELS = 10,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_wen_i,
  input  logic [lrst_pkg::LengthBits-1:0]    cfg_wdata_i,
  input  lrst_pkg::dp_op_e                   op_i,
  input  logic [lrst_pkg::CommandBits-1:0]   command_i,
  input  logic [lrst_pkg::LeftBits-1:0]      index_left_i,
  input  logic [lrst_pkg::RightBits-1:0]     index_right_i,
  input  logic signed [lrst_pkg::OperandBits-1:0] operand_value_i,
  output lrst_pkg::dp_status_t               status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [lrst_pkg::ResultBits-1:0] result_value_o,
  output logic                               error_o
);
  import lrst_pkg::*;

  localparam int unsigned LeafCount = 1 << TREE_LEVELS;
  localparam int unsigned Nw  = TREE_LEVELS + 2;          // node index incl. 2*LeafCount
  localparam int unsigned Saw = TREE_LEVELS + 1;          // sum memory address
  localparam int unsigned Paw = TREE_LEVELS;              // pending memory address
  localparam int unsigned Lvw = $clog2(TREE_LEVELS + 1);
  localparam int unsigned Hw  = $clog2(TREE_LEVELS + 2);
  localparam int unsigned Cw  = (Nw > LengthBits) ? Nw : LengthBits;
  localparam int unsigned Vb  = VALUE_BITS;

  // Tree storage
  logic [Vb-1:0] sum_mem  [2*LeafCount];
  logic [Vb-1:0] pend_mem [LeafCount];

  logic [Saw-1:0] sum_raddr, sum_waddr;
  logic [Paw-1:0] pend_raddr, pend_waddr;
  logic           sum_we, pend_we;
  logic [Vb-1:0]  sum_wdata, pend_wdata, sum_rd, pend_rd;

  // Control and payload registers
  logic [LengthBits-1:0] used_q;
  logic [Saw-1:0]        clr_q;
  logic [Nw-1:0]         l_q, r_q, a_q, b_q;
  logic [Lvw-1:0]        lvl_q;
  logic                  side_q;
  logic [Hw-1:0]         h_q;
  logic [Vb-1:0]         acc_q, tag_q, s0_q, opv_q;
  logic                  point_q, get_q, set_q, radd_q, rsum_q, total_q, err_q, done_q;
  logic                  out_valid_q, out_err_q;
  logic [ResultBits-1:0] out_data_q;

  // Load decode
  logic [Cw-1:0]   len_w, left_w, right_w;
  logic            ld_point, ld_err, ld_done, ld_total;
  logic [Nw-1:0]   ld_l, ld_r;
  logic [95:0]     opv_ext;
  logic [63+Vb:0]  acc_ext;
  cmd_e            cmd_w;

  // Node addressing for the push and pull passes
  logic [Nw-1:0] base_w, node_w, child0_w, child1_w, mask_w, bm1_w;
  logic          side_en_w;
  logic [Vb-1:0] walk_sum_w;
  logic [Nw-1:0] walk_node_w;
  logic          walk_internal_w;

  // Memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    pend_rd <= pend_mem[pend_raddr];
  end

  // Command decode and bounds checks at load
  always_comb begin
    cmd_w    = cmd_e'(command_i);
    len_w    = (Cw'(used_q) > Cw'(LeafCount)) ? Cw'(LeafCount) : Cw'(used_q);
    left_w   = Cw'(index_left_i);
    right_w  = Cw'(index_right_i);
    ld_point = 1'b0;
    ld_err   = 1'b0;
    ld_done  = 1'b0;
    ld_total = 1'b0;
    unique case (cmd_w)
      CMD_SET, CMD_GET, CMD_PADD: begin
        ld_point = 1'b1;
        ld_err   = (left_w >= len_w);
        ld_done  = ld_err;
      end
      CMD_RSUM, CMD_RADD: begin
        ld_err  = (left_w > right_w) || (right_w > len_w);
        ld_done = ld_err || (left_w == right_w);
      end
      CMD_TOTAL: begin
        ld_total = 1'b1;
      end
      default: begin
        ld_done = 1'b1;
      end
    endcase
    ld_l    = Nw'(LeafCount) + Nw'(index_left_i);
    ld_r    = ld_point ? (ld_l + Nw'(1)) : (Nw'(LeafCount) + Nw'(index_right_i));
    opv_ext = {{64{operand_value_i[OperandBits-1]}}, operand_value_i};
    acc_ext = {64'd0, acc_q};
  end

  // Node on the current level and side, and whether it takes part
  always_comb begin
    bm1_w     = r_q - Nw'(1);
    base_w    = side_q ? bm1_w : l_q;
    node_w    = base_w >> lvl_q;
    child0_w  = {node_w[Nw-2:0], 1'b0};
    child1_w  = {node_w[Nw-2:0], 1'b1};
    mask_w    = ~({Nw{1'b1}} << lvl_q);
    if (point_q) begin
      side_en_w = !side_q;
    end else if (side_q) begin
      side_en_w = (r_q & mask_w) != '0;
    end else begin
      side_en_w = (l_q & mask_w) != '0;
    end
    walk_node_w     = (op_i == OP_WALK_RD_B || op_i == OP_WALK_AP_B) ? b_q - Nw'(1) : a_q;
    walk_internal_w = walk_node_w < Nw'(LeafCount);
    walk_sum_w      = sum_rd + (opv_q << h_q);
  end

  // Memory port control
  always_comb begin
    sum_raddr  = '0;
    pend_raddr = '0;
    sum_we     = 1'b0;
    sum_waddr  = '0;
    sum_wdata  = '0;
    pend_we    = 1'b0;
    pend_waddr = '0;
    pend_wdata = '0;
    unique case (op_i)
      OP_CLR: begin
        sum_we     = 1'b1;
        sum_waddr  = clr_q;
        pend_we    = 1'b1;
        pend_waddr = clr_q[Paw-1:0];
      end
      OP_PUSH_TAG: begin
        pend_raddr = node_w[Paw-1:0];
      end
      OP_PUSH_ZERO: begin
        pend_we    = 1'b1;
        pend_waddr = node_w[Paw-1:0];
        sum_raddr  = child0_w[Saw-1:0];
        pend_raddr = child0_w[Paw-1:0];
      end
      OP_PUSH_C0, OP_PUSH_C1: begin
        sum_we     = 1'b1;
        sum_wdata  = sum_rd + (tag_q << (lvl_q - Lvw'(1)));
        pend_we    = lvl_q > Lvw'(1);
        pend_wdata = pend_rd + tag_q;
        if (op_i == OP_PUSH_C0) begin
          sum_waddr  = child0_w[Saw-1:0];
          pend_waddr = child0_w[Paw-1:0];
          sum_raddr  = child1_w[Saw-1:0];
          pend_raddr = child1_w[Paw-1:0];
        end else begin
          sum_waddr  = child1_w[Saw-1:0];
          pend_waddr = child1_w[Paw-1:0];
        end
      end
      OP_LEAF_RD: begin
        sum_raddr = l_q[Saw-1:0];
      end
      OP_LEAF_AP: begin
        sum_we    = !get_q;
        sum_waddr = l_q[Saw-1:0];
        sum_wdata = set_q ? opv_q : (sum_rd + opv_q);
      end
      OP_PULL_RD0: begin
        sum_raddr = child0_w[Saw-1:0];
      end
      OP_PULL_RD1: begin
        sum_raddr = child1_w[Saw-1:0];
      end
      OP_PULL_WR: begin
        sum_we    = 1'b1;
        sum_waddr = node_w[Saw-1:0];
        sum_wdata = s0_q + sum_rd;
      end
      OP_WALK_RD_A: begin
        sum_raddr  = a_q[Saw-1:0];
        pend_raddr = a_q[Paw-1:0];
      end
      OP_WALK_RD_B: begin
        sum_raddr  = walk_node_w[Saw-1:0];
        pend_raddr = walk_node_w[Paw-1:0];
      end
      OP_WALK_AP_A, OP_WALK_AP_B: begin
        sum_we     = radd_q;
        sum_waddr  = walk_node_w[Saw-1:0];
        sum_wdata  = walk_sum_w;
        pend_we    = radd_q && walk_internal_w;
        pend_waddr = walk_node_w[Paw-1:0];
        pend_wdata = pend_rd + opv_q;
      end
      OP_ROOT_RD: begin
        sum_raddr = Saw'(1);
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  // Configuration, clearing counter, level walk and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= UsedLengthReset;
      clr_q       <= '0;
      lvl_q       <= '0;
      side_q      <= 1'b0;
      point_q     <= 1'b0;
      get_q       <= 1'b0;
      set_q       <= 1'b0;
      radd_q      <= 1'b0;
      rsum_q      <= 1'b0;
      total_q     <= 1'b0;
      err_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wen_i) used_q <= cfg_wdata_i;
      if (op_i == OP_CLR) clr_q <= clr_q + Saw'(1);
      unique case (op_i)
        OP_LOAD: begin
          lvl_q   <= Lvw'(TREE_LEVELS);
          side_q  <= 1'b0;
          point_q <= ld_point;
          get_q   <= (cmd_w == CMD_GET);
          set_q   <= (cmd_w == CMD_SET);
          radd_q  <= (cmd_w == CMD_RADD);
          rsum_q  <= (cmd_w == CMD_RSUM);
          total_q <= ld_total;
          err_q   <= ld_err;
          done_q  <= ld_done;
        end
        OP_STEP_DOWN, OP_PUSH_C1: begin
          side_q <= !side_q;
          if (side_q) lvl_q <= lvl_q - Lvw'(1);
        end
        OP_STEP_UP, OP_PULL_WR: begin
          side_q <= !side_q;
          if (side_q) lvl_q <= lvl_q + Lvw'(1);
        end
        OP_LEAF_AP, OP_INIT_UP: begin
          lvl_q  <= Lvw'(1);
          side_q <= 1'b0;
        end
        default: begin
          side_q <= side_q;
        end
      endcase
      if (op_i == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        l_q   <= ld_l;
        r_q   <= ld_r;
        a_q   <= ld_l;
        b_q   <= ld_r;
        h_q   <= '0;
        acc_q <= '0;
        opv_q <= opv_ext[Vb-1:0];
      end
      OP_PUSH_ZERO: tag_q <= pend_rd;
      OP_PULL_RD1:  s0_q  <= sum_rd;
      OP_LEAF_AP:   if (get_q) acc_q <= sum_rd;
      OP_ROOT_AP:   acc_q <= sum_rd;
      OP_WALK_AP_A: begin
        if (rsum_q) acc_q <= acc_q + sum_rd;
        a_q <= a_q + Nw'(1);
      end
      OP_WALK_AP_B: begin
        if (rsum_q) acc_q <= acc_q + sum_rd;
        b_q <= walk_node_w;
      end
      OP_WALK_SHIFT: begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        h_q <= h_q + Hw'(1);
      end
      OP_OUT_LOAD: begin
        out_data_q <= acc_ext[ResultBits-1:0];
        out_err_q  <= err_q;
      end
      default: begin
        tag_q <= tag_q;
      end
    endcase
  end

  // Status towards the controller
  always_comb begin
    status_o.clr_last  = (clr_q == {Saw{1'b1}});
    status_o.go_done   = done_q;
    status_o.is_total  = total_q;
    status_o.is_point  = point_q;
    status_o.is_get    = get_q;
    status_o.is_radd   = radd_q;
    status_o.side_en   = side_en_w;
    status_o.push_last = (lvl_q == Lvw'(1)) && side_q;
    status_o.pull_last = (lvl_q == Lvw'(TREE_LEVELS)) && side_q;
    status_o.a_lt_b    = a_q < b_q;
    status_o.a_odd     = a_q[0];
    status_o.b_odd     = b_q[0];
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;
  assign error_o        = out_err_q;

  // Push and pull passes never work on the leaf level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_PUSH_TAG || op_i == OP_PULL_RD0 || op_i == OP_PULL_WR) |-> lvl_q != '0)
    else $error("tree pass issued at level zero");

  // Walk accesses only happen while the window is non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_WALK_RD_A || op_i == OP_WALK_RD_B) |-> a_q < b_q)
    else $error("walk access on an empty window");

  // An erroneous command always reports a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_OUT_LOAD && err_q) |=> (out_data_q == '0 && out_err_q))
    else $error("error transaction with non-zero result");

  // The root sum is only rewritten by clearing, by the pull pass or by the range walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_we && sum_waddr == Saw'(1)) |-> (op_i == OP_CLR || op_i == OP_PULL_WR ||
      op_i == OP_WALK_AP_A || op_i == OP_WALK_AP_B))
    else $error("unexpected write to the root sum");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lrst_pkg::*;

  localparam int unsigned LeafCount  = 1024;
  localparam int unsigned TreeLevels = 10;
  localparam int unsigned SettleCycles = 300;
  localparam longint unsigned CycleLimit = 3_000_000;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wen_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Model copy of the tree, tags and length register.
  logic [31:0] tree_sum [2*LeafCount];
  logic [31:0] tree_tag [LeafCount];
  logic [10:0] span_len;

  answer_t     answers_due [$];
  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  longint unsigned cycle_count = 0;
  bit          rx_hold = 1'b0;
  bit          rx_block = 1'b0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;

  lazy_range_add_sum_tree uut (
    .clk_i, .rst_ni, .cfg_wen_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the overall run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Apply a pending tag to a node covering 2^height leaves.
  function automatic void mark_node(int unsigned k, logic [31:0] f, int unsigned height);
    tree_sum[k] = tree_sum[k] + (f << height);
    if (k < LeafCount) tree_tag[k] = tree_tag[k] + f;
  endfunction

  function automatic void sink_tag(int unsigned k, int unsigned height);
    if (k == 0 || k >= LeafCount || height == 0) return;
    mark_node(2*k, tree_tag[k], height - 1);
    mark_node(2*k+1, tree_tag[k], height - 1);
    tree_tag[k] = '0;
  endfunction

  function automatic void refresh_node(int unsigned k);
    if (k == 0 || k >= LeafCount) return;
    tree_sum[k] = tree_sum[2*k] + tree_sum[2*k+1];
  endfunction

  // Work out the answer to one command and update the model tree.
  function automatic answer_t tree_answer(logic [2:0] op, logic [9:0] lo,
                                          logic [10:0] hi, logic [31:0] val);
    answer_t     ans;
    int unsigned len, p, l, r, a, b, h;
    logic [31:0] acc;
    ans = '0;
    acc = '0;
    len = (span_len > LeafCount) ? LeafCount : span_len;
    if (op == CMD_SET || op == CMD_GET || op == CMD_PADD) begin
      if (lo >= len) ans.error = 1'b1;
      else begin
        p = lo + LeafCount;
        for (int i = TreeLevels; i >= 1; i--) sink_tag(p >> i, i);
        if (op == CMD_GET) ans.value = tree_sum[p];
        else begin
          if (op == CMD_SET) tree_sum[p] = val;
          else tree_sum[p] = tree_sum[p] + val;
          for (int i = 1; i <= TreeLevels; i++) refresh_node(p >> i);
        end
      end
    end else if (op == CMD_RSUM || op == CMD_RADD) begin
      if (lo > hi || hi > len) ans.error = 1'b1;
      else if (lo != hi) begin
        l = lo + LeafCount;
        r = hi + LeafCount;
        for (int i = TreeLevels; i >= 1; i--) begin
          if (((l >> i) << i) != l) sink_tag(l >> i, i);
          if (((r >> i) << i) != r) sink_tag((r - 1) >> i, i);
        end
        a = l; b = r; h = 0;
        while (a < b) begin
          if (a & 1) begin
            if (op == CMD_RSUM) acc += tree_sum[a]; else mark_node(a, val, h);
            a++;
          end
          if (b & 1) begin
            b--;
            if (op == CMD_RSUM) acc += tree_sum[b]; else mark_node(b, val, h);
          end
          a >>= 1; b >>= 1; h++;
        end
        if (op == CMD_RSUM) ans.value = acc;
        else begin
          for (int i = 1; i <= TreeLevels; i++) begin
            if (((l >> i) << i) != l) refresh_node(l >> i);
            if (((r >> i) << i) != r) refresh_node((r - 1) >> i);
          end
        end
      end
    end else if (op == CMD_TOTAL) begin
      ans.value = tree_sum[1];
    end
    return ans;
  endfunction

  // Send one command and queue its expected answer on acceptance. The valid flag
  // stays up after acceptance so that a following command can go back to back;
  // an idle gap or a drain takes it down.
  task automatic send_item(logic [2:0] op, logic [9:0] lo, logic [10:0] hi,
                           logic [31:0] val);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, hi, lo, op};
    do @(posedge clk_i); while (!s_axis_tready);
    answers_due.insert(answers_due.size(), tree_answer(op, lo, hi, val));
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(logic [10:0] len);
    drain_results();
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_wen_i <= 1'b0;
    span_len = len;
  endtask

  // Receiver: random stalls, plus a long hold when asked.
  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold || rx_block) m_axis_tready <= 1'b0;
    else if (rx_idle_en && !m_axis_tready) m_axis_tready <= 1'b1;
    else if (rx_idle_en && $urandom_range(0, 7) == 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  // Stall bursts for the receiver are stretched by a separate counter.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (rx_idle_en && $urandom_range(0, 15) == 0) begin
        n = $urandom_range(1, 9);
        rx_hold = 1'b1;
        repeat (n) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    end
  end

  // Result checker: compare each transaction against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected result value=%h error=%b", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata !== want.value) begin
          failures++;
          $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata);
        end
        if (m_axis_tuser !== want.error) begin
          failures++;
          $display("%0t: error expected %b actual %b", $time, want.error, m_axis_tuser);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(int unsigned len);
    logic [2:0]  op;
    logic [9:0]  lo;
    logic [10:0] hi;
    int unsigned lim;
    lim = (len == 0) ? 1 : len;
    op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) begin
      lo = 10'($urandom); hi = 11'($urandom);
    end else begin
      lo = 10'($urandom_range(0, lim - 1));
      hi = 11'($urandom_range(lo, lim));
    end
    send_item(op, lo, hi, rand_word());
  endtask

  task automatic test_directed();
    send_item(CMD_TOTAL, 0, 0, 0);
    send_item(CMD_SET, 0, 0, 32'h7fff_ffff);
    send_item(CMD_SET, 1023, 0, 32'h8000_0000);
    send_item(CMD_GET, 1023, 0, 0);
    send_item(CMD_PADD, 0, 0, 32'h0000_0001);
    send_item(CMD_GET, 0, 0, 0);
    send_item(CMD_RADD, 0, 1024, 32'hffff_ffff);
    send_item(CMD_RSUM, 0, 1024, 0);
    send_item(CMD_RSUM, 5, 5, 0);
    send_item(CMD_RADD, 7, 7, 32'd9);
    send_item(CMD_RSUM, 6, 5, 0);
    send_item(CMD_RADD, 3, 517, 32'h1234_5678);
    send_item(CMD_RSUM, 1, 1023, 0);
    send_item(CMD_GET, 256, 0, 0);
    send_item(CMD_TOTAL, 0, 11'h7ff, 32'hffff_ffff);
    send_item(3'd6, 10'h3ff, 11'h7ff, 32'hffff_ffff);
    send_item(3'd7, 0, 0, 0);
  endtask

  task automatic test_lengths();
    write_length(11'd0);
    send_item(CMD_GET, 0, 0, 0);
    send_item(CMD_RSUM, 0, 0, 0);
    send_item(CMD_RSUM, 0, 1, 0);
    send_item(CMD_TOTAL, 0, 0, 0);
    repeat (40) random_item(0);
    write_length(11'd2047);
    send_item(CMD_RSUM, 0, 1024, 0);
    send_item(CMD_RSUM, 0, 1025, 0);
    repeat (60) random_item(1024);
    write_length(11'd1);
    repeat (40) random_item(1);
    write_length(11'd37);
    send_item(CMD_SET, 37, 0, 32'd5);
    repeat (150) random_item(37);
  endtask

  task automatic test_random();
    repeat (250) random_item(37);
    write_length(11'd1024);
    repeat (500) random_item(1024);
    write_length(11'd300);
    repeat (300) random_item(300);
  endtask

  // Hold the receiver off for a long time so the block backs up.
  task automatic test_backpressure();
    drain_results();
    fork
      begin
        rx_block = 1'b1;
        repeat (2000) @(posedge clk_i);
        rx_block = 1'b0;
      end
      repeat (10) random_item(300);
    join
    drain_results();
  endtask

  task automatic test_tail();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    write_length(11'd1024);
    repeat (150) random_item(1024);
  endtask

  initial begin
    foreach (tree_sum[i]) tree_sum[i] = '0;
    foreach (tree_tag[i]) tree_tag[i] = '0;
    span_len = UsedLengthReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_lengths();
    test_backpressure();
    test_random();
    test_tail();
    drain_results();
    $display("Sent %0d commands of all kinds, %0d results checked, over several lengths.",
             items_sent, results_seen);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
design/lrst_pkg.sv
design/lrst_ctrl.sv
design/lrst_dpath.sv
design/lazy_range_add_sum_tree.sv
dv/testbench.sv
